// ===== hdl/hbs_pkg.sv =====
// shared types, constants and helpers of the heightmap sampler
package hbs_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_U_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_EN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_U     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_V     = 3'd7;

    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    typedef struct packed {
        logic [16:0] map_width;
        logic [16:0] map_height;
        logic [2:0]  channel_count;
        logic [2:0]  orientation_flags;
        logic [15:0] u_offset;
        logic        smoothing_enable;
        logic [15:0] smooth_step_u;
        logic [15:0] smooth_step_v;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] texel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic signed [19:0] u_coord;
        logic signed [19:0] v_coord;
    } in_beat_t;

    // one bilinear tap request handed to the sampling pipeline
    typedef struct packed {
        logic        last;
        logic        empty;
        logic        smooth;
        logic [15:0] u;
        logic [16:0] v;
    } tap_t;

    function automatic logic [16:0] clamp_v(input logic signed [21:0] v);
        logic [16:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({5'd0, ONE_Q16}))
            r = ONE_Q16;
        else
            r = v[16:0];
        return r;
    endfunction

    function automatic logic [15:0] texel_h(input logic [23:0] t, input logic gray);
        logic [25:0] ws;
        logic [33:0] sc;
        logic [15:0] r;
        ws = 26'(t[23:16]) * 26'(LUMA_R) + 26'(t[15:8]) * 26'(LUMA_G)
           + 26'(t[7:0]) * 26'(LUMA_B);
        sc = 34'(ws) * 34'd257 + 34'd32768;
        if (gray)
            r = 16'(t[23:16] * 16'd257);
        else
            r = sc[31:16];
        return r;
    endfunction

endpackage

// ===== hdl/hbs_stream_if.sv =====
// valid/ready stream channel
interface hbs_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/hbs_tap_gen.sv =====
// coordinate transform and generation of one or five bilinear taps per sample
module hbs_tap_gen
(
    input  logic              clk,
    input  logic              rst_n,
    input  hbs_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  hbs_pkg::in_beat_t in_data,
    output logic              tap_valid,
    input  logic              tap_ready,
    output hbs_pkg::tap_t     tap
);
    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] u_reg;
    logic signed [21:0] v_reg;
    logic        smooth_reg, empty_reg;
    logic signed [21:0] us, vs, ut, vt;
    logic [15:0] uw, tu;
    logic signed [21:0] tv;

    always_comb
    begin
        us = 22'(in_data.u_coord);
        vs = 22'(in_data.v_coord);
        ut = cfg.orientation_flags[0] ? vs : us;
        vt = cfg.orientation_flags[0] ? us : vs;
        if (cfg.orientation_flags[1])
            ut = 22'sd65536 - ut;
        if (cfg.orientation_flags[2])
            vt = 22'sd65536 - vt;
        uw = 16'(ut) + cfg.u_offset;
    end

    assign in_ready = tap_ready && (!busy_reg || tap.last);

    always_comb
    begin
        tu = u_reg;
        tv = v_reg;
        case (cnt_reg)
            3'd1: tu = u_reg - cfg.smooth_step_u;
            3'd2: tu = u_reg + cfg.smooth_step_u;
            3'd3: tv = v_reg - $signed({6'd0, cfg.smooth_step_v});
            3'd4: tv = v_reg + $signed({6'd0, cfg.smooth_step_v});
            default: ;
        endcase
    end

    assign tap_valid = busy_reg;
    assign tap.u = tu;
    assign tap.v = hbs_pkg::clamp_v(tv);
    assign tap.empty = empty_reg;
    assign tap.smooth = smooth_reg && !empty_reg;
    assign tap.last = !smooth_reg || empty_reg || cnt_reg == 3'd4;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        if (busy_reg && tap_ready)
        begin
            if (tap.last)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 3'd1;
        end
        if (in_valid && in_ready && in_data.mode)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.mode)
        begin
            u_reg <= uw;
            v_reg <= vt;
            smooth_reg <= cfg.smoothing_enable;
            empty_reg <= cfg.map_width == '0 || cfg.map_height == '0;
        end
    end
endmodule

// ===== hdl/hbs_bilinear.sv =====
// pipelined bilinear tap: address, four-bank texel fetch, row mix, column mix
module hbs_bilinear
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbs_pkg::cfg_t              cfg,
    input  logic                       wr_en,
    input  logic [hbs_pkg::ADDR_W-1:0] wr_addr,
    input  logic [23:0]                wr_data,
    input  logic                       tap_valid,
    output logic                       tap_ready,
    input  hbs_pkg::tap_t              tap,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [16:0]                res_height,
    output logic                       res_last,
    output logic                       res_smooth
);
    localparam int AW = hbs_pkg::ADDR_W;
    localparam int NS = 6;

    logic [23:0] mem0 [hbs_pkg::STORE_DEPTH];
    logic [23:0] mem1 [hbs_pkg::STORE_DEPTH];
    logic [23:0] mem2 [hbs_pkg::STORE_DEPTH];
    logic [23:0] mem3 [hbs_pkg::STORE_DEPTH];

    logic [NS-1:0] v_reg;
    logic          adv;
    logic [2:0]    last_reg [NS];

    logic          wr_v1_reg, wr_v2_reg;
    logic [AW-1:0] wr_a1_reg, wr_a2_reg;
    logic [23:0]   wr_d1_reg, wr_d2_reg;

    logic [32:0] fx1_reg, fy1_reg;
    logic [15:0] sx2_reg, sy2_reg, sx3_reg, sy3_reg, sx4_reg, sy4_reg, sy5_reg;
    logic [AW-1:0] a00_reg, a01_reg, a10_reg, a11_reg;
    logic [23:0] t00_reg, t01_reg, t10_reg, t11_reg;
    logic [15:0] h00_reg, h01_reg, h10_reg, h11_reg;
    logic [32:0] r0_reg, r1_reg;
    logic [16:0] out_reg;
    logic        empty_reg [NS];

    logic [16:0] x0, y0, x1, y1, xp, yp;
    logic [32:0] row0, row1, acc_rnd;
    logic [49:0] acc;

    assign adv = !v_reg[NS-1] || res_ready;
    assign tap_ready = adv;
    assign res_valid = v_reg[NS-1];
    assign res_height = out_reg;
    assign res_last = last_reg[NS-1][0];
    assign res_smooth = last_reg[NS-1][1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            wr_v1_reg <= 1'b0;
            wr_v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], tap_valid};
            wr_v1_reg <= wr_en;
            wr_v2_reg <= wr_v1_reg;
        end
    end

    // writes trail the taps already issued until those pass the fetch stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wr_a1_reg <= wr_addr;
            wr_d1_reg <= wr_data;
            wr_a2_reg <= wr_a1_reg;
            wr_d2_reg <= wr_d1_reg;
            if (wr_v2_reg)
            begin
                mem0[wr_a2_reg] <= wr_d2_reg;
                mem1[wr_a2_reg] <= wr_d2_reg;
                mem2[wr_a2_reg] <= wr_d2_reg;
                mem3[wr_a2_reg] <= wr_d2_reg;
            end
        end
    end

    always_comb
    begin
        x0 = fx1_reg[32:16];
        y0 = fy1_reg[32:16];
        x1 = x0 + 17'd1;
        if (x1 >= cfg.map_width)
            x1 = '0;
        y1 = y0 + 17'd1;
        if (y1 >= cfg.map_height)
            y1 = cfg.map_height - 17'd1;
        yp = y0;
        xp = y1;
        row0 = 33'(h00_reg) * 33'(hbs_pkg::ONE_Q16 - 17'(sx4_reg))
             + 33'(h01_reg) * 33'(sx4_reg);
        row1 = 33'(h10_reg) * 33'(hbs_pkg::ONE_Q16 - 17'(sx4_reg))
             + 33'(h11_reg) * 33'(sx4_reg);
        acc = 50'(r0_reg) * 50'(hbs_pkg::ONE_Q16 - 17'(sy5_reg))
            + 50'(r1_reg) * 50'(sy5_reg) + 50'h80000000;
        acc_rnd = acc[48:32] == 17'd0 ? 33'd0 : 33'(acc[48:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg[0] <= {1'b0, tap.smooth, tap.last};
            empty_reg[0] <= tap.empty;
            for (int i = 1; i < NS; i++)
            begin
                last_reg[i] <= last_reg[i-1];
                empty_reg[i] <= empty_reg[i-1];
            end
            // stage 1: scale coordinates
            fx1_reg <= 33'(tap.u) * 33'(cfg.map_width - 17'd1);
            fy1_reg <= 33'(tap.v) * 33'(cfg.map_height - 17'd1);
            // stage 2: texel addresses
            sx2_reg <= fx1_reg[15:0];
            sy2_reg <= fy1_reg[15:0];
            a00_reg <= AW'(34'(yp) * 34'(cfg.map_width) + 34'(x0));
            a01_reg <= AW'(34'(yp) * 34'(cfg.map_width) + 34'(x1));
            a10_reg <= AW'(34'(xp) * 34'(cfg.map_width) + 34'(x0));
            a11_reg <= AW'(34'(xp) * 34'(cfg.map_width) + 34'(x1));
            // stage 3: banked fetch
            t00_reg <= mem0[a00_reg];
            t01_reg <= mem1[a01_reg];
            t10_reg <= mem2[a10_reg];
            t11_reg <= mem3[a11_reg];
            sx3_reg <= sx2_reg;
            sy3_reg <= sy2_reg;
            // stage 4: texel heights
            h00_reg <= hbs_pkg::texel_h(t00_reg, cfg.channel_count == 3'd1);
            h01_reg <= hbs_pkg::texel_h(t01_reg, cfg.channel_count == 3'd1);
            h10_reg <= hbs_pkg::texel_h(t10_reg, cfg.channel_count == 3'd1);
            h11_reg <= hbs_pkg::texel_h(t11_reg, cfg.channel_count == 3'd1);
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            // stage 5: row mix
            r0_reg <= row0;
            r1_reg <= row1;
            sy5_reg <= sy4_reg;
            // stage 6: column mix and rounding
            out_reg <= empty_reg[NS-2] ? hbs_pkg::HALF_Q16 : acc_rnd[16:0];
        end
    end
endmodule

// ===== hdl/hbs_average.sv =====
// rounded mean of five smoothed taps or one plain tap, with output register
module hbs_average
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    output logic        res_ready,
    input  logic [16:0] res_height,
    input  logic        res_last,
    input  logic        res_smooth,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] out_height
);
    logic [19:0] sum_reg, sum_next, tot;
    logic [1:0]  dv_reg;
    logic [19:0] div_in_reg;
    logic        div_sm_reg;
    logic [16:0] div_pass_reg;
    logic [16:0] out_reg;
    logic [39:0] prod;
    logic [19:0] q;
    logic        adv;

    assign adv = !dv_reg[1] || out_ready;
    assign res_ready = adv;
    assign out_valid = dv_reg[1];
    assign out_height = out_reg;
    assign tot = sum_reg + 20'(res_height);
    assign sum_next = (res_valid && res_last) ? '0 : (res_valid ? tot : sum_reg);

    // (sum + 2) / 5 by reciprocal multiply, exact for sums below 2^20
    always_comb
    begin
        prod = 40'(div_in_reg + 20'd2) * 40'd838861;
        q = 20'(prod[39:22]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
            sum_reg <= '0;
        end
        else if (adv)
        begin
            dv_reg <= {dv_reg[0], res_valid && res_last};
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_in_reg <= tot;
            div_sm_reg <= res_smooth;
            div_pass_reg <= res_height;
            out_reg <= div_sm_reg ? q[16:0] : div_pass_reg;
        end
    end
endmodule

// ===== hdl/heightmap_bilinear_sampler.sv =====
// top level of the heightmap bilinear sampler
// A load beat (mode 0) writes one texel and yields no result. A sample beat (mode 1)
// yields one height: without smoothing a new sample is taken every cycle while the output
// does not stall; with smoothing a new sample is taken once the previous one has issued
// its last tap, set by the single bilinear pipeline that evaluates one tap per cycle
// unless the output stalls, from four banked copies of the texel store; loads also wait
// while a smoothed sample issues its taps. The store needs no clearing and is valid once
// written.
module heightmap_bilinear_sampler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    hbs_stream_if.sink                        in_ch,
    hbs_stream_if.source                      out_ch
);
    hbs_pkg::cfg_t     cfg_reg;
    hbs_pkg::in_beat_t in_beat;
    hbs_pkg::tap_t     tap;
    logic tap_valid, tap_ready, gen_ready;
    logic res_valid, res_ready, res_last, res_smooth;
    logic [16:0] res_height, out_height;

    assign in_beat = hbs_pkg::in_beat_t'(in_ch.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width <= '0;
            cfg_reg.map_height <= '0;
            cfg_reg.channel_count <= 3'd1;
            cfg_reg.orientation_flags <= '0;
            cfg_reg.u_offset <= '0;
            cfg_reg.smoothing_enable <= 1'b0;
            cfg_reg.smooth_step_u <= 16'd64;
            cfg_reg.smooth_step_v <= 16'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hbs_pkg::REG_MAP_WIDTH:  cfg_reg.map_width <= cfg_data;
                hbs_pkg::REG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data;
                hbs_pkg::REG_CHANNELS:   cfg_reg.channel_count <= cfg_data[2:0];
                hbs_pkg::REG_ORIENT:     cfg_reg.orientation_flags <= cfg_data[2:0];
                hbs_pkg::REG_U_OFFSET:   cfg_reg.u_offset <= cfg_data[15:0];
                hbs_pkg::REG_SMOOTH_EN:  cfg_reg.smoothing_enable <= cfg_data[0];
                hbs_pkg::REG_STEP_U:     cfg_reg.smooth_step_u <= cfg_data[15:0];
                hbs_pkg::REG_STEP_V:     cfg_reg.smooth_step_v <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = gen_ready;

    hbs_tap_gen u_gen
    (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_ch.valid), .in_ready(gen_ready), .in_data(in_beat),
        .tap_valid(tap_valid), .tap_ready(tap_ready), .tap(tap)
    );

    hbs_bilinear u_bil
    (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .wr_en(in_ch.valid && gen_ready && !in_beat.mode),
        .wr_addr(in_beat.texel_index[hbs_pkg::ADDR_W-1:0]),
        .wr_data({in_beat.red, in_beat.green, in_beat.blue}),
        .tap_valid(tap_valid), .tap_ready(tap_ready), .tap(tap),
        .res_valid(res_valid), .res_ready(res_ready), .res_height(res_height),
        .res_last(res_last), .res_smooth(res_smooth)
    );

    hbs_average u_avg
    (
        .clk(clk), .rst_n(rst_n),
        .res_valid(res_valid), .res_ready(res_ready), .res_height(res_height),
        .res_last(res_last), .res_smooth(res_smooth),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_height(out_height)
    );

    assign out_ch.data = out_height;
endmodule

// ===== hdl/hbs_checker.sv =====
// port-level assertions for the heightmap sampler
module hbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data <= 17'd65536)
        else $error("height above one");
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat right after reset");
endmodule

bind heightmap_bilinear_sampler hbs_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== verif/heightmap_bilinear_sampler_tb.sv =====
// testbench of the heightmap bilinear sampler: predicted heights checked beat by beat
module heightmap_bilinear_sampler_tb;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    hbs_stream_if #(.W($bits(hbs_pkg::in_beat_t))) in_ch ();
    hbs_stream_if #(.W(17)) out_ch ();

    heightmap_bilinear_sampler uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #6 clk = ~clk;

    hbs_pkg::cfg_t cfg_model;
    logic [23:0] texel_model [hbs_pkg::STORE_DEPTH];
    logic [16:0] height_expect_q [$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint texel_height_of(longint col, longint row);
        longint addr;
        longint r;
        longint g;
        longint b;
        addr = (row * longint'(cfg_model.map_width) + col) % hbs_pkg::STORE_DEPTH;
        r = texel_model[addr][23:16];
        g = texel_model[addr][15:8];
        b = texel_model[addr][7:0];
        if (cfg_model.channel_count == 3'd1)
            return r * 257;
        return ((13933 * r + 46871 * g + 4732 * b) * 257 + 32768) >> 16;
    endfunction

    function automatic longint bilinear_tap(longint u, longint v);
        longint w;
        longint h;
        longint vc;
        longint fx;
        longint fy;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint sx;
        longint sy;
        longint h0;
        longint h1;
        longint acc;
        w = cfg_model.map_width;
        h = cfg_model.map_height;
        vc = (v < 0) ? 0 : ((v > 65536) ? 65536 : v);
        fx = (u & 'hFFFF) * (w - 1);
        fy = vc * (h - 1);
        x0 = fx >> 16;
        sx = fx & 'hFFFF;
        y0 = fy >> 16;
        sy = fy & 'hFFFF;
        x1 = (x0 + 1 >= w) ? 0 : x0 + 1;
        y1 = (y0 + 1 >= h) ? h - 1 : y0 + 1;
        h0 = texel_height_of(x0, y0) * (65536 - sx) + texel_height_of(x1, y0) * sx;
        h1 = texel_height_of(x0, y1) * (65536 - sx) + texel_height_of(x1, y1) * sx;
        acc = h0 * (65536 - sy) + h1 * sy;
        return (acc + 64'h8000_0000) >> 32;
    endfunction

    function automatic logic [16:0] predict_height(hbs_pkg::in_beat_t b);
        longint u;
        longint v;
        longint t;
        longint du;
        longint dv;
        longint sum;
        if (cfg_model.map_width == 0 || cfg_model.map_height == 0)
            return hbs_pkg::HALF_Q16;
        u = longint'($signed(b.u_coord));
        v = longint'($signed(b.v_coord));
        if (cfg_model.orientation_flags[0])
        begin
            t = u;
            u = v;
            v = t;
        end
        if (cfg_model.orientation_flags[1])
            u = 65536 - u;
        if (cfg_model.orientation_flags[2])
            v = 65536 - v;
        u = (u + longint'(cfg_model.u_offset)) & 'hFFFF;
        if (!cfg_model.smoothing_enable)
            return 17'(bilinear_tap(u, v));
        du = cfg_model.smooth_step_u;
        dv = cfg_model.smooth_step_v;
        sum = bilinear_tap(u, v) + bilinear_tap(u - du, v) + bilinear_tap(u + du, v)
            + bilinear_tap(u, v - dv) + bilinear_tap(u, v + dv);
        return 17'((sum + 2) / 5);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(hbs_pkg::in_beat_t b);
        int gap;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (b.mode)
            height_expect_q = {height_expect_q, predict_height(b)};
        else
            texel_model[b.texel_index] = {b.red, b.green, b.blue};
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (height_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [hbs_pkg::CFG_IDX_W-1:0] idx,
                             logic [hbs_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            hbs_pkg::REG_MAP_WIDTH:  cfg_model.map_width = val;
            hbs_pkg::REG_MAP_HEIGHT: cfg_model.map_height = val;
            hbs_pkg::REG_CHANNELS:   cfg_model.channel_count = val[2:0];
            hbs_pkg::REG_ORIENT:     cfg_model.orientation_flags = val[2:0];
            hbs_pkg::REG_U_OFFSET:   cfg_model.u_offset = val[15:0];
            hbs_pkg::REG_SMOOTH_EN:  cfg_model.smoothing_enable = val[0];
            hbs_pkg::REG_STEP_U:     cfg_model.smooth_step_u = val[15:0];
            hbs_pkg::REG_STEP_V:     cfg_model.smooth_step_v = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(int chans, int flags, int offs, int smooth, int su, int sv);
        write_reg(hbs_pkg::REG_CHANNELS, 17'(chans));
        write_reg(hbs_pkg::REG_ORIENT, 17'(flags));
        write_reg(hbs_pkg::REG_U_OFFSET, 17'(offs));
        write_reg(hbs_pkg::REG_SMOOTH_EN, 17'(smooth));
        write_reg(hbs_pkg::REG_STEP_U, 17'(su));
        write_reg(hbs_pkg::REG_STEP_V, 17'(sv));
    endtask

    function automatic hbs_pkg::in_beat_t rand_beat(bit mode);
        hbs_pkg::in_beat_t b;
        b.mode = mode;
        b.texel_index = 16'($urandom());
        b.red = 8'($urandom());
        b.green = 8'($urandom());
        b.blue = 8'($urandom());
        b.u_coord = 20'($urandom());
        b.v_coord = 20'($urandom());
        if (mode && $urandom_range(0, 2) != 0)
        begin
            b.u_coord = 20'($urandom_range(0, 65536));
            b.v_coord = 20'($urandom_range(0, 65536));
        end
        return b;
    endfunction

    task automatic send_sample(int u, int v);
        hbs_pkg::in_beat_t b;
        b = rand_beat(1'b1);
        b.u_coord = 20'(u);
        b.v_coord = 20'(v);
        send_beat(b);
    endtask

    // sets the map size and fills every texel it covers
    task automatic load_map(int w, int h, bit extremes);
        hbs_pkg::in_beat_t b;
        write_reg(hbs_pkg::REG_MAP_WIDTH, 17'(w));
        write_reg(hbs_pkg::REG_MAP_HEIGHT, 17'(h));
        for (int i = 0; i < w * h; i++)
        begin
            b = rand_beat(1'b0);
            b.texel_index = 16'(i);
            if (extremes)
            begin
                b.red = (i % 2) ? 8'hFF : 8'h00;
                b.green = (i % 3) ? 8'hFF : 8'h00;
                b.blue = (i % 2) ? 8'h00 : 8'hFF;
            end
            send_beat(b);
        end
    endtask

    task automatic test_empty_map();
        send_sample(0, 0);
        send_sample(-524288, 524287);
        write_reg(hbs_pkg::REG_MAP_WIDTH, 17'h10000);
        send_sample(524287, -524288);
        wait_idle();
    endtask

    task automatic test_directed();
        load_map(1, 1, 1'b1);
        send_sample(32768, 32768);
        wait_idle();
        load_map(2, 2, 1'b1);
        set_mode(3, 0, 0, 0, 64, 64);
        send_sample(0, 0);
        send_sample(65536, 65536);
        send_sample(-524288, -524288);
        send_sample(524287, 524287);
        send_sample(32768, 98304);
        wait_idle();
        for (int f = 0; f < 8; f++)
        begin
            set_mode((f % 2) ? 4 : 7, f, (f > 3) ? 65535 : 0, 0, 64, 64);
            send_sample(20000, 50000);
            wait_idle();
        end
        set_mode(0, 0, 0, 1, 0, 0);
        send_sample(40000, 10000);
        wait_idle();
        set_mode(1, 0, 0, 1, 65535, 65535);
        send_sample(40000, 10000);
        send_sample(0, 65536);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int w;
        int h;
        int n;
        hbs_pkg::in_beat_t b;
        for (int p = 0; p < 12; p++)
        begin
            calm = (p % 4 == 3);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            if (p == 5)
                w = 1;
            if (p == 6)
                h = 1;
            load_map(w, h, 1'b0);
            set_mode($urandom_range(0, 7), $urandom_range(0, 7),
                     ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535),
                     $urandom_range(0, 1),
                     ($urandom_range(0, 1)) ? $urandom_range(0, 512) : $urandom_range(0, 65535),
                     ($urandom_range(0, 1)) ? $urandom_range(0, 512) : $urandom_range(0, 65535));
            n = $urandom_range(10, 22);
            for (int i = 0; i < n; i++)
            begin
                b = rand_beat($urandom_range(0, 4) != 0);
                if (!b.mode && $urandom_range(0, 1))
                    b.texel_index = 16'($urandom_range(0, w * h - 1));
                send_beat(b);
                if (i == n / 2 && p % 3 == 0)
                    wait_idle();
            end
            wait_idle();
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (calm)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                           : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (height_expect_q.size() == 0)
            begin
                $display("%0t: unexpected height beat %0d", $time, out_ch.data);
                errors++;
            end
            else if (out_ch.data !== height_expect_q[0])
            begin
                $display("%0t: height expected %0d actual %0d", $time,
                         height_expect_q[0], out_ch.data);
                errors++;
                void'(height_expect_q.pop_front());
            end
            else
                void'(height_expect_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("heightmap_bilinear_sampler_tb failed");
            $finish;
        end
    end

    initial
    begin
        cfg_model = '0;
        cfg_model.channel_count = 3'd1;
        cfg_model.smooth_step_u = 16'd64;
        cfg_model.smooth_step_v = 16'd64;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_empty_map();
        test_directed();
        test_random_phases();
        wait_idle();
        if (errors == 0)
            $display("heightmap_bilinear_sampler_tb passed");
        else
            $display("heightmap_bilinear_sampler_tb failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/hbs_pkg.sv
hdl/hbs_stream_if.sv
hdl/hbs_tap_gen.sv
hdl/hbs_bilinear.sv
hdl/hbs_average.sv
hdl/heightmap_bilinear_sampler.sv
hdl/hbs_checker.sv
verif/heightmap_bilinear_sampler_tb.sv
